[design/ppmcd_pkg.sv]
// ppmcd_pkg: types and constants shared by the ppm channel decoder
// no dependencies; compiled first

package ppmcd_pkg;

    // field widths
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned WIDTH_W = 15;
    localparam int unsigned TALLY_W = 2;

    // reset value of the sync threshold in microseconds
    localparam logic [WIDTH_W-1:0] SYNC_THRESHOLD_RESET = WIDTH_W'(3000);

    // overflow tally at or above this value means pulses are missing
    localparam logic [TALLY_W-1:0] MISSING_TALLY = TALLY_W'(2);

    // input item kinds
    typedef enum logic {
        REQ_EDGE     = 1'b0,
        REQ_OVERFLOW = 1'b1
    } t_req_kind;

    // result item kinds
    typedef enum logic {
        EVT_PULSE   = 1'b0,
        EVT_MISSING = 1'b1
    } t_event_kind;

    // one input item
    typedef struct packed {
        t_req_kind         req_type;
        logic [TIME_W-1:0] capture_time;
    } t_in_item;

    // one result item
    typedef struct packed {
        t_event_kind        event_kind;
        logic [CHAN_W-1:0]  channel_index;
        logic [WIDTH_W-1:0] pulse_width_us;
    } t_result;

    // handshake between decode stage and output register
    typedef struct packed {
        logic advance;
        logic res_valid;
    } t_stage_ctrl;

endpackage

[design/ppmcd_in_if.sv]
// ppmcd_in_if: input channel carrying timer events
// depends on ppmcd_pkg

interface ppmcd_in_if
    import ppmcd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [TIME_W-1:0] capture_time;

    modport source (output valid, output req_type, output capture_time, input ready);
    modport sink   (input valid, input req_type, input capture_time, output ready);
endinterface

[design/ppmcd_out_if.sv]
// ppmcd_out_if: output channel carrying decoded pulse and missing events
// depends on ppmcd_pkg

interface ppmcd_out_if
    import ppmcd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               event_kind;
    logic [CHAN_W-1:0]  channel_index;
    logic [WIDTH_W-1:0] pulse_width_us;

    modport source (output valid, output event_kind, output channel_index,
                    output pulse_width_us, input ready);
    modport sink   (input valid, input event_kind, input channel_index,
                    input pulse_width_us, output ready);
endinterface

[design/ppmcd_in_reg.sv]
// ppmcd_in_reg: input register holding one timer event for the decode stage
// depends on ppmcd_pkg

module ppmcd_in_reg
    import ppmcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_accept;

    // free when empty or when the held item moves on this cycle
    assign o_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[design/ppmcd_decode.sv]
// ppmcd_decode: framing and interval decode, one event per cycle unless the output is full
// depends on ppmcd_pkg

module ppmcd_decode
    import ppmcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_in_item           i_item,
    input  logic [WIDTH_W-1:0] i_sync_threshold,
    input  logic               i_out_free,
    output t_stage_ctrl        o_ctrl,
    output t_result            o_result
);

    logic [TALLY_W-1:0] r_tally;
    logic [TALLY_W-1:0] n_tally;
    logic [CHAN_W-1:0]  r_chan;
    logic [CHAN_W-1:0]  n_chan;
    logic [TIME_W-1:0]  r_last;
    logic [TIME_W-1:0]  n_last;

    logic               w_missing;
    logic [TIME_W-1:0]  w_diff;
    logic [WIDTH_W-1:0] w_width;
    logic               w_is_sync;
    logic               w_res_valid;
    logic               w_advance;

    // interval since last edge, halved to microseconds
    assign w_missing = (r_tally >= MISSING_TALLY);
    assign w_diff    = i_item.capture_time - r_last;
    assign w_width   = w_diff[TIME_W-1:1];
    assign w_is_sync = (w_width >= i_sync_threshold);

    // next state and result
    always_comb begin
        n_tally     = r_tally;
        n_chan      = r_chan;
        n_last      = r_last;
        w_res_valid = 1'b0;
        o_result    = '{event_kind: EVT_PULSE, channel_index: r_chan,
                        pulse_width_us: w_width};
        if (i_item.req_type == REQ_OVERFLOW) begin
            if (w_missing) begin
                n_chan      = '0;
                w_res_valid = 1'b1;
                o_result    = '{event_kind: EVT_MISSING, channel_index: '0,
                                pulse_width_us: '0};
            end else begin
                n_tally = r_tally + TALLY_W'(1);
            end
        end else if (w_missing) begin
            // first edge after loss re-arms the timestamp and clears channel and tally, with no result
            n_chan  = '0;
            n_tally = '0;
            n_last  = i_item.capture_time;
        end else begin
            n_last = i_item.capture_time;
            if (w_is_sync) begin
                n_chan  = CHAN_W'(1);
                n_tally = '0;
            end else begin
                w_res_valid = 1'b1;
                n_chan      = r_chan + CHAN_W'(1);
            end
        end
    end

    // an item moves on unless its result finds the output register full
    assign w_advance = i_valid && (!w_res_valid || i_out_free);
    assign o_ctrl    = '{advance: w_advance, res_valid: w_res_valid};

    // framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= MISSING_TALLY;
            r_chan  <= '0;
            r_last  <= '0;
        end else if (w_advance) begin
            r_tally <= n_tally;
            r_chan  <= n_chan;
            r_last  <= n_last;
        end
    end

endmodule

[design/ppmcd_out_reg.sv]
// ppmcd_out_reg: result register toward the output channel
// depends on ppmcd_pkg

module ppmcd_out_reg
    import ppmcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stage_ctrl i_ctrl,
    input  t_result     i_result,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;
    logic    w_load;

    assign o_free = !r_valid || i_ready;
    assign w_load = i_ctrl.advance && i_ctrl.res_valid;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[design/ppm_channel_decoder_top.sv]
// ppm_channel_decoder_top: rc ppm pulse position decoder, top level
// depends on ppmcd_pkg, ppmcd_in_if, ppmcd_out_if, ppmcd_in_reg, ppmcd_decode,
// ppmcd_out_reg
//
//   channel   dir  handshake     payload
//   i_item    in   valid/ready   req_type, capture_time
//   o_result  out  valid/ready   event_kind, channel_index, pulse_width_us
//   cfg       in   i_cfg_we      i_cfg_wdata (sync threshold, us)
//
// one item per cycle sustained unless a full output register stalls; an item is
// held in the input register and its result is loaded into the output register
// the decode stage is a single subtract and compare against the framing state
// synchronous active-low reset: tally in missing state, channel 0, timestamp 0,
// threshold 3000 us
// a full output register holds back only items that produce a result

module ppm_channel_decoder_top
    import ppmcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    ppmcd_in_if.sink           i_item,
    ppmcd_out_if.source        o_result,
    input  logic               i_cfg_we,
    input  logic [WIDTH_W-1:0] i_cfg_wdata
);

    logic [WIDTH_W-1:0] r_sync_threshold;
    t_in_item           w_in_item;
    t_in_item           w_held_item;
    logic               w_in_valid;
    logic               w_out_free;
    t_stage_ctrl        w_ctrl;
    t_result            w_dec_result;
    t_result            w_out_result;

    // sync threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_threshold <= SYNC_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_sync_threshold <= i_cfg_wdata;
        end
    end

    assign w_in_item = '{req_type: t_req_kind'(i_item.req_type),
                         capture_time: i_item.capture_time};

    // input register
    ppmcd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_item.valid),
        .i_item    (w_in_item),
        .o_ready   (i_item.ready),
        .i_advance (w_ctrl.advance),
        .o_valid   (w_in_valid),
        .o_item    (w_held_item)
    );

    // decode stage
    ppmcd_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_in_valid),
        .i_item           (w_held_item),
        .i_sync_threshold (r_sync_threshold),
        .i_out_free       (w_out_free),
        .o_ctrl           (w_ctrl),
        .o_result         (w_dec_result)
    );

    // output register
    ppmcd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_result (w_dec_result),
        .o_free   (w_out_free),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (w_out_result)
    );

    assign o_result.event_kind     = w_out_result.event_kind;
    assign o_result.channel_index  = w_out_result.channel_index;
    assign o_result.pulse_width_us = w_out_result.pulse_width_us;

`ifndef NO_ASSERTIONS
    // a result only moves into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.advance && w_ctrl.res_valid) |-> (!o_result.valid || o_result.ready))
        else $error("result loaded into occupied output register");

    // an accepted item is held for decode on the next cycle
    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> w_in_valid)
        else $error("accepted item not held in input register");

    // missing events carry zero channel and width
    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.event_kind == EVT_MISSING)
            |-> (o_result.channel_index == '0 && o_result.pulse_width_us == '0))
        else $error("missing event with nonzero fields");

    // no result is produced without an item in the decode stage
    a_res_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.advance |-> w_in_valid)
        else $error("decode advanced with no item");
`endif

endmodule
